[design/bcdr_pkg.sv]
package bcdr_pkg;

  // Copy burst granule in bytes, a power of two
  localparam int unsigned LINE_BYTES = 64;
  localparam logic [28:0] LineMask   = 29'(LINE_BYTES - 1);

  // Register values after reset
  localparam logic [12:0] ScrWidthRst  = 13'd1024;
  localparam logic [12:0] ScrHeightRst = 13'd768;
  localparam logic [16:0] LinePitchRst = 17'd4096;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CmdBlit  = 2'd0,
    CmdFlush = 2'd1,
    CmdRow   = 2'd2
  } bcdr_cmd_e;

  // Register indexes on the configuration port (byte address / 4)
  typedef enum logic [1:0] {
    RegScrWidth  = 2'd0,
    RegScrHeight = 2'd1,
    RegLinePitch = 2'd2
  } bcdr_reg_e;

  // One input word
  typedef struct packed {
    logic [1:0]         command;
    logic signed [12:0] pos_x;
    logic signed [12:0] pos_y;
    logic [12:0]        size_w;
    logic [12:0]        size_h;
    logic [13:0]        src_pitch;
    logic [12:0]        span_right;
    logic [12:0]        span_bottom;
    logic [11:0]        row_y;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic        valid_res;
    logic [12:0] rect_x0;
    logic [12:0] rect_y0;
    logic [12:0] rect_x1;
    logic [12:0] rect_y1;
    logic [25:0] src_skip;
    logic [28:0] mem_offset;
    logic [14:0] mem_bytes;
  } res_word_t;

endpackage

[design/bcdr_in_if.sv]
interface bcdr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [12:0] pos_x;
  logic signed [12:0] pos_y;
  logic [12:0]        size_w;
  logic [12:0]        size_h;
  logic [13:0]        src_pitch;
  logic [12:0]        span_right;
  logic [12:0]        span_bottom;
  logic [11:0]        row_y;

  modport source (
    output valid, command, pos_x, pos_y, size_w, size_h, src_pitch,
           span_right, span_bottom, row_y,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, size_w, size_h, src_pitch,
           span_right, span_bottom, row_y,
    output ready
  );
endinterface

[design/bcdr_out_if.sv]
interface bcdr_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [12:0] rect_x0;
  logic [12:0] rect_y0;
  logic [12:0] rect_x1;
  logic [12:0] rect_y1;
  logic [25:0] src_skip;
  logic [28:0] mem_offset;
  logic [14:0] mem_bytes;

  modport source (
    output valid, valid_res, rect_x0, rect_y0, rect_x1, rect_y1, src_skip,
           mem_offset, mem_bytes,
    input  ready
  );
  modport sink (
    input  valid, valid_res, rect_x0, rect_y0, rect_x1, rect_y1, src_skip,
           mem_offset, mem_bytes,
    output ready
  );
endinterface

[design/blit_clip_dirty_rect_tracker_unit.sv]
// Blit clipping and dirty-rectangle tracker.
// Input channel in_i carries command words: blit request, flush of the
// dirty rectangle, or row span query. Output channel out_o returns exactly
// one result word for every accepted command word, in order.
// An APB-style port sets screen width (0x0), screen height (0x4) and line
// pitch in bytes (0x8); write it only while no word is in flight.
// An accepted word sits in the input register and passes the clip/offset
// logic into the result register, which offers it, once that register is
// free or being taken. Throughput is one word per cycle while results are
// taken; the limit is the single pass through a 12x17 offset multiply and
// its adder. A word waits in the input register while the result register
// is held, so a stalled receiver costs no throughput until both registers are
// full; then ready drops and both words hold until the receiver takes one.
// Reset empties both registers, loads the screen registers with 1024x768,
// pitch 4096, and sets the dirty rectangle to empty (left/top at the screen
// size, right/bottom at zero). No clearing pass is needed.
module blit_clip_dirty_rect_tracker_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcdr_in_if.sink           in_i,
  bcdr_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [12:0] scr_width_q, scr_height_q;
  logic [16:0] line_pitch_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_width_q  <= bcdr_pkg::ScrWidthRst;
      scr_height_q <= bcdr_pkg::ScrHeightRst;
      line_pitch_q <= bcdr_pkg::LinePitchRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bcdr_pkg::RegScrWidth:  scr_width_q  <= pwdata[12:0];
        bcdr_pkg::RegScrHeight: scr_height_q <= pwdata[12:0];
        bcdr_pkg::RegLinePitch: line_pitch_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      bcdr_pkg::RegScrWidth:  prdata = {19'd0, scr_width_q};
      bcdr_pkg::RegScrHeight: prdata = {19'd0, scr_height_q};
      bcdr_pkg::RegLinePitch: prdata = {15'd0, line_pitch_q};
      default:                prdata = 32'd0;
    endcase
  end

  // Handshake: input register feeds result register
  logic                 in_valid_q, out_valid_q;
  bcdr_pkg::in_word_t   in_q;
  bcdr_pkg::res_word_t  res_q, res_d;
  logic [1:0]           res_cmd_q;
  logic                 st_en, in_en;

  assign st_en      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_en      = in_i.valid && in_i.ready;
  assign in_i.ready = !in_valid_q || st_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (!out_valid_q || out_o.ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_en) begin
      in_q <= '{command:     in_i.command,
                pos_x:       in_i.pos_x,
                pos_y:       in_i.pos_y,
                size_w:      in_i.size_w,
                size_h:      in_i.size_h,
                src_pitch:   in_i.src_pitch,
                span_right:  in_i.span_right,
                span_bottom: in_i.span_bottom,
                row_y:       in_i.row_y};
    end
  end

  // Dirty rectangle
  logic [12:0] dirty_left_q, dirty_top_q, dirty_right_q, dirty_bottom_q;

  // Blit clipping, done in 15-bit signed arithmetic
  logic signed [14:0] bx, by, bxe, bye, sw15, sh15;
  logic signed [14:0] bx0, by0, bex, bey, bwid;
  logic               b_vis;
  logic [12:0]        neg_x, neg_y;
  logic [26:0]        skip_prod;
  logic [25:0]        b_skip;

  always_comb begin
    bx   = 15'(in_q.pos_x);
    by   = 15'(in_q.pos_y);
    sw15 = $signed({2'b00, scr_width_q});
    sh15 = $signed({2'b00, scr_height_q});
    bxe  = bx + $signed({2'b00, in_q.size_w});
    bye  = by + $signed({2'b00, in_q.size_h});
    b_vis = !(bx >= sw15 || bxe <= 15'sd0 || by >= sh15 || bye <= 15'sd0);
    bex  = (bxe > sw15) ? sw15 : bxe;
    bey  = (bye > sh15) ? sh15 : bye;
    bx0  = (bx < 15'sd0) ? 15'sd0 : bx;
    by0  = (by < 15'sd0) ? 15'sd0 : by;
    bwid = bex - bx0;
    neg_x = (bx < 15'sd0) ? 13'(-bx) : 13'd0;
    neg_y = (by < 15'sd0) ? 13'(-by) : 13'd0;
    skip_prod = neg_y * in_q.src_pitch;
    b_skip = 26'(neg_x) + skip_prod[25:0];
  end

  // Row query bounds
  logic signed [14:0] r_top, r_row;
  logic               r_in;
  logic [11:0]        r_left;
  logic [14:0]        r_width;
  logic [12:0]        r_diff;

  always_comb begin
    r_top  = 15'(in_q.pos_y);
    r_row  = $signed({3'b000, in_q.row_y});
    r_in   = (r_top <= r_row) && (r_row < $signed({2'b00, in_q.span_bottom}));
    r_left = in_q.pos_x[12] ? 12'd0 : in_q.pos_x[11:0];
    r_diff = in_q.span_right - {1'b0, r_left};
    r_width = (in_q.span_right > {1'b0, r_left}) ? {r_diff, 2'b00} : 15'd0;
  end

  // Shared destination offset: row times pitch plus four bytes per pixel
  logic [11:0] ofs_row, ofs_col;
  logic [28:0] ofs_prod, ofs_sum;
  logic [15:0] len_sum;
  logic [14:0] r_len;

  always_comb begin
    if (in_q.command == bcdr_pkg::CmdBlit) begin
      ofs_row = by0[11:0];
      ofs_col = bx0[11:0];
    end else begin
      ofs_row = in_q.row_y;
      ofs_col = r_left;
    end
    ofs_prod = ofs_row * line_pitch_q;
    ofs_sum  = ofs_prod + {15'd0, ofs_col, 2'b00};
    len_sum  = 16'(r_width) + 16'(ofs_sum & bcdr_pkg::LineMask)
             + 16'(bcdr_pkg::LineMask);
    r_len    = len_sum[14:0] & ~15'(bcdr_pkg::LineMask);
  end

  // Select the result word
  always_comb begin
    res_d = '0;
    unique case (in_q.command)
      bcdr_pkg::CmdBlit: begin
        if (b_vis) begin
          res_d.valid_res  = 1'b1;
          res_d.rect_x0    = bx0[12:0];
          res_d.rect_y0    = by0[12:0];
          res_d.rect_x1    = bex[12:0];
          res_d.rect_y1    = bey[12:0];
          res_d.src_skip   = b_skip;
          res_d.mem_offset = ofs_sum;
          res_d.mem_bytes  = {bwid[12:0], 2'b00};
        end
      end
      bcdr_pkg::CmdFlush: begin
        res_d.valid_res = (dirty_left_q < dirty_right_q) &&
                          (dirty_top_q < dirty_bottom_q);
        res_d.rect_x0   = dirty_left_q;
        res_d.rect_y0   = dirty_top_q;
        res_d.rect_x1   = dirty_right_q;
        res_d.rect_y1   = dirty_bottom_q;
      end
      bcdr_pkg::CmdRow: begin
        if (r_in) begin
          res_d.valid_res  = 1'b1;
          res_d.rect_x0    = {1'b0, r_left};
          res_d.rect_y0    = {1'b0, in_q.row_y};
          res_d.rect_x1    = in_q.span_right;
          res_d.rect_y1    = {1'b0, in_q.row_y} + 13'd1;
          res_d.mem_offset = ofs_sum & ~bcdr_pkg::LineMask;
          res_d.mem_bytes  = r_len;
        end
      end
      default: ;
    endcase
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (st_en) begin
      res_q     <= res_d;
      res_cmd_q <= in_q.command;
    end
  end

  // Grow the dirty rectangle on a visible blit, empty it on a flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_left_q   <= bcdr_pkg::ScrWidthRst;
      dirty_top_q    <= bcdr_pkg::ScrHeightRst;
      dirty_right_q  <= '0;
      dirty_bottom_q <= '0;
    end else if (st_en) begin
      if (in_q.command == bcdr_pkg::CmdBlit && b_vis) begin
        if (dirty_left_q > bx0[12:0])    dirty_left_q   <= bx0[12:0];
        if (dirty_top_q > by0[12:0])     dirty_top_q    <= by0[12:0];
        if (dirty_right_q < bex[12:0])   dirty_right_q  <= bex[12:0];
        if (dirty_bottom_q < bey[12:0])  dirty_bottom_q <= bey[12:0];
      end else if (in_q.command == bcdr_pkg::CmdFlush) begin
        dirty_left_q   <= scr_width_q;
        dirty_top_q    <= scr_height_q;
        dirty_right_q  <= '0;
        dirty_bottom_q <= '0;
      end
    end
  end

  // Drive the output channel
  assign out_o.valid      = out_valid_q;
  assign out_o.valid_res  = res_q.valid_res;
  assign out_o.rect_x0    = res_q.rect_x0;
  assign out_o.rect_y0    = res_q.rect_y0;
  assign out_o.rect_x1    = res_q.rect_x1;
  assign out_o.rect_y1    = res_q.rect_y1;
  assign out_o.src_skip   = res_q.src_skip;
  assign out_o.mem_offset = res_q.mem_offset;
  assign out_o.mem_bytes  = res_q.mem_bytes;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("input refused with empty input register");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_en))
    else $error("result word appeared without a word passing through");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_en && in_q.command == bcdr_pkg::CmdFlush) |=>
      (dirty_right_q == 13'd0 && dirty_bottom_q == 13'd0))
    else $error("dirty rectangle not emptied by flush");

  a_dirty_covers_blit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_en && in_q.command == bcdr_pkg::CmdBlit && b_vis) |=>
      (dirty_left_q <= res_q.rect_x0 && dirty_top_q <= res_q.rect_y0 &&
       dirty_right_q >= res_q.rect_x1 && dirty_bottom_q >= res_q.rect_y1))
    else $error("dirty rectangle misses a visible blit");

  a_row_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_cmd_q == bcdr_pkg::CmdRow) |->
      ((res_q.mem_offset & bcdr_pkg::LineMask) == 29'd0 &&
       (res_q.mem_bytes & 15'(bcdr_pkg::LineMask)) == 15'd0))
    else $error("row span not aligned to the line granule");
`endif

endmodule
